// ===== hw/rtl/xtu_pkg.sv =====
// Shared types and constants of the XML text unescaper.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package xtu_pkg;

    localparam int WIN_DEPTH   = 10;
    localparam int CFG_W       = 21;
    localparam int COUNT_W     = 20;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_W-1:0] LIMIT_RESET      = 21'd1048576;
    localparam longint unsigned  MAX_OUTPUT_BYTES = 64'd1048576;
    localparam longint unsigned  COUNT_MAX        = (64'd1 << COUNT_W) - 64'd1;

    typedef logic [WIN_DEPTH-1:0][7:0] t_win;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               is_end;
        logic [COUNT_W-1:0] out_count;
    } t_out_item;

    typedef enum logic {
        OP_EMIT,
        OP_END
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
    } t_op;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_CDATA,
        MODE_COMMENT
    } t_mode;

    typedef enum logic {
        FS_RUN,
        FS_FLUSH
    } t_front_state;

endpackage

`default_nettype wire

// ===== hw/rtl/xtu_front.sv =====
// Front end of the unescaper: lookahead window, entity and section recognition.
// Pushes emit and end operations into the queue. Depends on xtu_pkg.
`default_nettype none

module xtu_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire xtu_pkg::t_in_item i_in_data,
    output logic                   o_push,
    output xtu_pkg::t_op           o_op,
    input  wire logic              i_q_full
);
    import xtu_pkg::*;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    localparam logic [31:0] PAT_LT      = "&lt;";
    localparam logic [31:0] PAT_GT      = "&gt;";
    localparam logic [39:0] PAT_AMP     = "&amp;";
    localparam logic [47:0] PAT_APOS    = "&apos;";
    localparam logic [47:0] PAT_QUOT    = "&quot;";
    localparam logic [71:0] PAT_CDATA   = "<![CDATA[";
    localparam logic [31:0] PAT_COMMENT = "<!--";
    localparam logic [23:0] PAT_CCLOSE  = "-->";
    localparam logic [23:0] PAT_DCLOSE  = "]]>";

    t_front_state r_state, n_state;
    t_win         r_win, n_win;
    logic [3:0]   r_fill, n_fill;
    t_mode        r_mode, n_mode;
    logic [3:0]   r_skip, n_skip;
    logic         r_halted, n_halted;

    t_win       cand_win, shift_win;
    logic [3:0] cand_fill;
    logic       accept, do_decide;
    logic       c_emit;
    logic [7:0] c_byte;
    logic [3:0] c_skip;
    t_mode      c_mode;

    assign o_in_stall = i_q_full || (r_state == FS_FLUSH);
    assign accept     = i_in_valid && !o_in_stall;

    // Window as seen by a decision: append the incoming byte while running.
    always_comb begin
        cand_win  = r_win;
        cand_fill = r_fill;
        if (r_state == FS_RUN && !r_halted && r_fill < 4'(WIN_DEPTH)) begin
            cand_win[r_fill] = i_in_data.in_byte;
            cand_fill        = r_fill + 4'd1;
        end
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            shift_win[i] = cand_win[i+1];
        end
        shift_win[WIN_DEPTH-1] = 8'd0;
    end

    // Classify the head byte.
    always_comb begin
        c_emit = 1'b0;
        c_byte = cand_win[0];
        c_skip = 4'd0;
        c_mode = r_mode;
        priority if (r_mode == MODE_TEXT && cand_win[0] == CH_AMP) begin
            c_emit = 1'b1;
            priority if (cand_fill >= 4'd4 &&
                         {cand_win[0], cand_win[1], cand_win[2], cand_win[3]} == PAT_LT) begin
                c_byte = CH_LT;
                c_skip = 4'd3;
            end else if (cand_fill >= 4'd4 &&
                         {cand_win[0], cand_win[1], cand_win[2], cand_win[3]} == PAT_GT) begin
                c_byte = CH_GT;
                c_skip = 4'd3;
            end else if (cand_fill >= 4'd5 &&
                         {cand_win[0], cand_win[1], cand_win[2], cand_win[3],
                          cand_win[4]} == PAT_AMP) begin
                c_byte = CH_AMP;
                c_skip = 4'd4;
            end else if (cand_fill >= 4'd6 &&
                         {cand_win[0], cand_win[1], cand_win[2], cand_win[3],
                          cand_win[4], cand_win[5]} == PAT_APOS) begin
                c_byte = CH_APOS;
                c_skip = 4'd5;
            end else if (cand_fill >= 4'd6 &&
                         {cand_win[0], cand_win[1], cand_win[2], cand_win[3],
                          cand_win[4], cand_win[5]} == PAT_QUOT) begin
                c_byte = CH_QUOT;
                c_skip = 4'd5;
            end else begin
                c_byte = CH_AMP;
            end
        end else if (r_mode == MODE_TEXT && cand_win[0] == CH_LT && cand_fill > 4'd1 &&
                     cand_win[1] == CH_BANG) begin
            // Openers need more bytes behind them than their own length.
            priority if (cand_fill >= 4'd10 &&
                         {cand_win[0], cand_win[1], cand_win[2], cand_win[3], cand_win[4],
                          cand_win[5], cand_win[6], cand_win[7], cand_win[8]} == PAT_CDATA)
            begin
                c_skip = 4'd8;
                c_mode = MODE_CDATA;
            end else if (cand_fill >= 4'd5 &&
                         {cand_win[0], cand_win[1], cand_win[2], cand_win[3]} == PAT_COMMENT)
            begin
                c_skip = 4'd3;
                c_mode = MODE_COMMENT;
            end else begin
                c_emit = 1'b1;
            end
        end else if (r_mode == MODE_COMMENT && cand_fill >= 4'd3 &&
                     {cand_win[0], cand_win[1], cand_win[2]} == PAT_CCLOSE) begin
            c_skip = 4'd2;
            c_mode = MODE_TEXT;
        end else if (r_mode == MODE_CDATA && cand_fill >= 4'd3 &&
                     {cand_win[0], cand_win[1], cand_win[2]} == PAT_DCLOSE) begin
            c_skip = 4'd2;
            c_mode = MODE_TEXT;
        end else if (r_mode != MODE_COMMENT) begin
            c_emit = 1'b1;
        end else begin
            c_emit = 1'b0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_win     = r_win;
        n_fill    = r_fill;
        n_mode    = r_mode;
        n_skip    = r_skip;
        n_halted  = r_halted;
        do_decide = 1'b0;
        o_push    = 1'b0;
        o_op.kind = OP_EMIT;
        o_op.data = c_byte;

        unique case (r_state)
            FS_RUN: begin
                if (accept) begin
                    if (!r_halted) begin
                        n_win  = cand_win;
                        n_fill = cand_fill;
                    end
                    if (i_in_data.last_byte) begin
                        n_state = FS_FLUSH;
                    end else if (!r_halted && cand_fill == 4'(WIN_DEPTH)) begin
                        do_decide = 1'b1;
                    end
                end
            end
            FS_FLUSH: begin
                if (!i_q_full) begin
                    if (r_fill != 4'd0) begin
                        do_decide = 1'b1;
                    end else begin
                        // Close the text and return to reset state.
                        o_push    = 1'b1;
                        o_op.kind = OP_END;
                        o_op.data = 8'd0;
                        n_state   = FS_RUN;
                        n_mode    = MODE_TEXT;
                        n_skip    = 4'd0;
                        n_halted  = 1'b0;
                    end
                end
            end
        endcase

        if (do_decide) begin
            priority if (r_skip != 4'd0) begin
                n_skip = r_skip - 4'd1;
                n_win  = shift_win;
                n_fill = cand_fill - 4'd1;
            end else if (cand_win[0] == CH_NUL) begin
                n_halted = 1'b1;
                n_fill   = 4'd0;
                n_skip   = 4'd0;
            end else begin
                n_win  = shift_win;
                n_fill = cand_fill - 4'd1;
                n_skip = c_skip;
                n_mode = c_mode;
                o_push = c_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_RUN;
            r_fill   <= 4'd0;
            r_mode   <= MODE_TEXT;
            r_skip   <= 4'd0;
            r_halted <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_mode   <= n_mode;
            r_skip   <= n_skip;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 4'(WIN_DEPTH))
        else $error("window fill beyond depth");

    a_skip_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= r_fill)
        else $error("skip count exceeds buffered bytes");

    a_halt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_fill == 4'd0)
        else $error("halted with bytes in window");

    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.last_byte) |=> r_state == FS_FLUSH)
        else $error("last byte did not start flush");

endmodule

`default_nettype wire

// ===== hw/rtl/xtu_queue.sv =====
// Short operation queue between front and back of the unescaper.
// Register-based FIFO of xtu_pkg::t_op entries. Depends on xtu_pkg.
`default_nettype none

module xtu_queue #(
    parameter int DEPTH = xtu_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire xtu_pkg::t_op i_data,
    output logic              o_full,
    output logic              o_valid,
    output xtu_pkg::t_op      o_data,
    input  wire logic         i_pop
);
    import xtu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/xtu_back.sv =====
// Back end of the unescaper: output limit, byte count and output register.
// Pops queue operations and forms result beats. Depends on xtu_pkg.
`default_nettype none

module xtu_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [xtu_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_q_valid,
    input  wire xtu_pkg::t_op              i_op,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output xtu_pkg::t_out_item             o_out_data
);
    import xtu_pkg::*;

    // Clamp the limit, leave room for the terminator, saturate to the count field.
    function automatic logic [COUNT_W-1:0] cap_of(input logic [CFG_W-1:0] lim_in);
        logic [63:0] lim;
        logic [63:0] cap;
        lim = 64'(lim_in);
        if (lim > MAX_OUTPUT_BYTES) lim = MAX_OUTPUT_BYTES;
        cap = (lim == 64'd0) ? 64'd0 : lim - 64'd1;
        if (cap > COUNT_MAX) cap = COUNT_MAX;
        return cap[COUNT_W-1:0];
    endfunction

    logic [COUNT_W-1:0] r_cap;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic               load_ok;
    logic [COUNT_W-1:0] cnt_inc;

    assign load_ok     = !r_out_valid || !i_out_stall;
    assign o_pop       = i_q_valid && load_ok;
    assign cnt_inc     = r_count + 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_count     = r_count;
        if (o_pop) begin
            unique case (i_op.kind)
                OP_END: begin
                    n_out_valid       = 1'b1;
                    n_out.out_byte    = 8'd0;
                    n_out.is_end      = 1'b1;
                    n_out.out_count   = r_count;
                    n_count           = '0;
                end
                OP_EMIT: begin
                    // Drop bytes once the limit is reached.
                    if (r_count < r_cap) begin
                        n_out_valid     = 1'b1;
                        n_out.out_byte  = i_op.data;
                        n_out.is_end    = 1'b0;
                        n_out.out_count = cnt_inc;
                        n_count         = cnt_inc;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= cap_of(LIMIT_RESET);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= cap_of(i_cfg_data);
            end
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_end) |-> o_out_data.out_count <= r_cap)
        else $error("emitted byte beyond output limit");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_end) |-> o_out_data.out_byte == 8'd0)
        else $error("end beat carries a byte");

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.kind == OP_END) |=> r_count == '0)
        else $error("count not cleared after end of text");

endmodule

`default_nettype wire

// ===== hw/rtl/xml_text_unescaper_top.sv =====
// Top level of the XML text unescaper: front, operation queue and back.
// Depends on xtu_pkg, xtu_front, xtu_queue and xtu_back.
//
// Usage
//   Input channel carries one text byte per beat, the final byte of a text
//   marked by last_byte. Output channel carries decoded bytes with their
//   running count, then one end beat (is_end set, out_byte zero) with the
//   total. Both channels use valid/stall; a beat moves when valid is high
//   and stall is low.
//   Configuration: pulse i_cfg_we with i_cfg_data = output limit (capacity
//   including terminator); at most limit minus one bytes are emitted.
// Timing
//   Throughput is one input byte per cycle while o_in_stall is low. A byte
//   is decided once nine more bytes sit behind it in the ten-byte window;
//   it enters the queue at the edge that accepts the ninth of those bytes
//   and from there passes to the output register.
//   After a last byte the front flushes the window one byte per cycle while
//   the queue is not full, then issues the end beat; input is stalled until
//   the end operation enters the queue.
// Reset and stall
//   Reset clears the window, section mode and count, and sets the limit to
//   1048576. When the receiver stalls, the output register holds its beat,
//   the queue fills, and once it is full the input stall rises.
`default_nettype none

module xml_text_unescaper_top #(
    parameter int QUEUE_DEPTH = xtu_pkg::QUEUE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire xtu_pkg::t_in_item         i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output xtu_pkg::t_out_item             o_out_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [xtu_pkg::CFG_W-1:0] i_cfg_data
);
    import xtu_pkg::*;

    // Operation path: front pushes, back pops.
    logic q_push, q_full, q_valid, q_pop;
    t_op  q_wr_op, q_rd_op;

    // Front: accept bytes, hold the window, recognize entities and sections.
    xtu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (q_push),
        .o_op       (q_wr_op),
        .i_q_full   (q_full)
    );

    // Decouple the two sides so either can stall on its own.
    xtu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rd_op),
        .i_pop   (q_pop)
    );

    // Back: apply the output limit, count bytes, drive the output beat.
    xtu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_op        (q_rd_op),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
